@@ sv/dmsh_pkg.sv @@
// Shared constants, codes, command and status types for the substring hash block.
`default_nettype none

package dmsh_pkg;

    // Default string capacity
    localparam int DEF_MAX_LEN = 1024;

    // First prime lane
    localparam int PA_W = 30;
    localparam logic [PA_W-1:0] PRIME_A = 30'd1000000009;

    // Second prime lane
    localparam int PB_W = 27;
    localparam logic [PB_W-1:0] PRIME_B = 27'd100000007;

    localparam logic [9:0] HASH_BASE   = 10'd1001;
    localparam logic [7:0] CHAR_OFFSET = 8'd96;

    // Barrett reciprocals: floor(2^(2W) / P), W+1 bits wide
    localparam logic [63:0] BAR_A_FULL = (64'd1 << (2 * PA_W)) / 64'(PRIME_A);
    localparam logic [63:0] BAR_B_FULL = (64'd1 << (2 * PB_W)) / 64'(PRIME_B);
    localparam logic [PA_W:0] BAR_M_A = BAR_A_FULL[PA_W:0];
    localparam logic [PB_W:0] BAR_M_B = BAR_B_FULL[PB_W:0];

    // Inverse of the base by Fermat, evaluated at elaboration
    function automatic logic [PA_W-1:0] f_base_inv_a();
        logic [63:0]     acc;
        logic [63:0]     sq;
        logic [PA_W-1:0] e;
        acc = 64'd1;
        sq  = 64'(HASH_BASE);
        e   = PRIME_A - PA_W'(2);
        for (int i = 0; i < PA_W; i++) begin
            if (e[i]) acc = (acc * sq) % 64'(PRIME_A);
            sq = (sq * sq) % 64'(PRIME_A);
        end
        return acc[PA_W-1:0];
    endfunction

    function automatic logic [PB_W-1:0] f_base_inv_b();
        logic [63:0]     acc;
        logic [63:0]     sq;
        logic [PB_W-1:0] e;
        acc = 64'd1;
        sq  = 64'(HASH_BASE);
        e   = PRIME_B - PB_W'(2);
        for (int i = 0; i < PB_W; i++) begin
            if (e[i]) acc = (acc * sq) % 64'(PRIME_B);
            sq = (sq * sq) % 64'(PRIME_B);
        end
        return acc[PB_W-1:0];
    endfunction

    localparam logic [PA_W-1:0] BASE_INV_A = f_base_inv_a();
    localparam logic [PB_W-1:0] BASE_INV_B = f_base_inv_b();

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic issue_append;
        logic commit_append;
        logic read_query;
        logic diff_query;
        logic issue_query;
        logic hold_result;
        logic hold_error;
        logic push;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic  req_valid;
        t_kind kind;
        logic  full;
        logic  range_bad;
        logic  mul_done;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ sv/double_mod_substring_hash.sv @@
// Top level of the double-modulus substring hash block.
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the kind (clear, append,
//   query, no operation), tdata the character code and the two substring indices.
//   Each query request yields one result on the m_axis channel: both hashes in
//   tdata and the range error flag in tuser; other kinds yield nothing.
//   One request is worked on at a time. Clear, no-op and dropped appends (string
//   full) finish at acceptance. An append issues to the multipliers, waits for
//   their result and commits; a good query reads the tables, forms the prefix
//   difference, issues it to the multiplier, waits and pushes its result; a
//   query with a bad range goes straight to the push. Each append and good query
//   passes once through the five-stage Barrett multiplier; an append adds its
//   term to the tail with one fold. A result waits in the output register while
//   the next request is accepted; if the receiver stalls, the next query holds in
//   its final step until the output register drains. Reset empties the string and
//   the output register; the hash tables keep stale contents, which are only used
//   below the stored length and so always written since the last clear.
`default_nettype none

module double_mod_substring_hash #(
    parameter int MAX_LEN = dmsh_pkg::DEF_MAX_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [7:0] char_code, [17:8] left_index,
                                               // [27:18] right_index, [31:28] zero
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    // result channel
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // [29:0] hash_first, [56:30] hash_second,
                                               // [63:57] zero
    output logic [0:0]       o_m_axis_tuser    // [0] range_error
);

    dmsh_pkg::t_cmd  cmd;
    dmsh_pkg::t_stat stat;

    logic [dmsh_pkg::PA_W-1:0] hash_first;
    logic [dmsh_pkg::PB_W-1:0] hash_second;
    logic                      range_error;

    // Sequence each request through the datapath
    dmsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_s_axis_tready)
    );

    // Tables, running powers, multipliers and the output register
    dmsh_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .i_req_kind    (i_s_axis_tuser),
        .i_req_code    (i_s_axis_tdata[7:0]),
        .i_req_left    (i_s_axis_tdata[17:8]),
        .i_req_right   (i_s_axis_tdata[27:18]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_hash_first  (hash_first),
        .o_hash_second (hash_second),
        .o_range_error (range_error)
    );

    // Pack the result; pad the top of tdata with zeros
    assign o_m_axis_tdata = {7'd0, hash_second, hash_first};
    assign o_m_axis_tuser = range_error;

endmodule

`default_nettype wire

@@ sv/dmsh_modmul.sv @@
// Five-stage Barrett modular multiplier, one lane per prime.
`default_nettype none

module dmsh_modmul (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [dmsh_pkg::PA_W-1:0] i_a_first,
    input  wire logic [dmsh_pkg::PA_W-1:0] i_b_first,
    input  wire logic [dmsh_pkg::PB_W-1:0] i_a_second,
    input  wire logic [dmsh_pkg::PB_W-1:0] i_b_second,
    output logic                           o_valid,
    output logic [dmsh_pkg::PA_W-1:0]      o_y_first,
    output logic [dmsh_pkg::PB_W-1:0]      o_y_second
);

    localparam int AW  = dmsh_pkg::PA_W;
    localparam int BW  = dmsh_pkg::PB_W;
    localparam int ARW = AW + 2;
    localparam int BRW = BW + 2;

    localparam logic [ARW-1:0] A_P1 = ARW'(dmsh_pkg::PRIME_A);
    localparam logic [ARW-1:0] A_P2 = ARW'(dmsh_pkg::PRIME_A) << 1;
    localparam logic [BRW-1:0] B_P1 = BRW'(dmsh_pkg::PRIME_B);
    localparam logic [BRW-1:0] B_P2 = BRW'(dmsh_pkg::PRIME_B) << 1;

    logic [4:0] r_vld;

    logic [2*AW-1:0]   n_x_a, r_x_a;
    logic [2*AW+1:0]   n_qm_a, r_qm_a;
    logic [ARW-1:0]    r_x2_a, r_x3_a;
    logic [ARW-1:0]    n_qp_a, r_qp_a;
    logic [ARW-1:0]    n_r_a, r_r_a;
    logic [AW-1:0]     n_y_a, r_y_a;

    logic [2*BW-1:0]   n_x_b, r_x_b;
    logic [2*BW+1:0]   n_qm_b, r_qm_b;
    logic [BRW-1:0]    r_x2_b, r_x3_b;
    logic [BRW-1:0]    n_qp_b, r_qp_b;
    logic [BRW-1:0]    n_r_b, r_r_b;
    logic [BW-1:0]     n_y_b, r_y_b;

    always_comb begin
        n_x_a  = (2*AW)'(i_a_first) * (2*AW)'(i_b_first);
        n_qm_a = (2*AW+2)'(r_x_a[2*AW-1:AW-1]) * (2*AW+2)'(dmsh_pkg::BAR_M_A);
        n_qp_a = ARW'(r_qm_a[2*AW:AW+1]) * A_P1;
        n_r_a  = r_x3_a - r_qp_a;
        if (r_r_a >= A_P2) begin
            n_y_a = AW'(r_r_a - A_P2);
        end else if (r_r_a >= A_P1) begin
            n_y_a = AW'(r_r_a - A_P1);
        end else begin
            n_y_a = AW'(r_r_a);
        end

        n_x_b  = (2*BW)'(i_a_second) * (2*BW)'(i_b_second);
        n_qm_b = (2*BW+2)'(r_x_b[2*BW-1:BW-1]) * (2*BW+2)'(dmsh_pkg::BAR_M_B);
        n_qp_b = BRW'(r_qm_b[2*BW:BW+1]) * B_P1;
        n_r_b  = r_x3_b - r_qp_b;
        if (r_r_b >= B_P2) begin
            n_y_b = BW'(r_r_b - B_P2);
        end else if (r_r_b >= B_P1) begin
            n_y_b = BW'(r_r_b - B_P1);
        end else begin
            n_y_b = BW'(r_r_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Payload stages run freely; the valid line marks the live slot
    always_ff @(posedge i_clk) begin
        r_x_a  <= n_x_a;
        r_qm_a <= n_qm_a;
        r_x2_a <= r_x_a[ARW-1:0];
        r_qp_a <= n_qp_a;
        r_x3_a <= r_x2_a;
        r_r_a  <= n_r_a;
        r_y_a  <= n_y_a;

        r_x_b  <= n_x_b;
        r_qm_b <= n_qm_b;
        r_x2_b <= r_x_b[BRW-1:0];
        r_qp_b <= n_qp_b;
        r_x3_b <= r_x2_b;
        r_r_b  <= n_r_b;
        r_y_b  <= n_y_b;
    end

    assign o_valid    = r_vld[4];
    assign o_y_first  = r_y_a;
    assign o_y_second = r_y_b;

endmodule

`default_nettype wire

@@ sv/dmsh_datapath.sv @@
// Datapath: request registers, running powers, hash tables, multipliers, output register.
`default_nettype none

module dmsh_datapath #(
    parameter int MAX_LEN = dmsh_pkg::DEF_MAX_LEN
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req_valid,
    input  wire logic [1:0]                i_req_kind,
    input  wire logic [7:0]                i_req_code,
    input  wire logic [9:0]                i_req_left,
    input  wire logic [9:0]                i_req_right,
    input  wire dmsh_pkg::t_cmd            i_cmd,
    output dmsh_pkg::t_stat                o_stat,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic [dmsh_pkg::PA_W-1:0]      o_hash_first,
    output logic [dmsh_pkg::PB_W-1:0]      o_hash_second,
    output logic                           o_range_error
);

    localparam int AW = dmsh_pkg::PA_W;
    localparam int BW = dmsh_pkg::PB_W;
    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > 10) ? LW : 10;

    // Request registers
    logic [7:0]  r_code;
    logic [9:0]  r_left;
    logic [9:0]  r_right;

    // Architectural state
    logic [LW-1:0] r_len;
    logic [AW-1:0] r_pow_a, r_inv_a, r_tail_a;
    logic [BW-1:0] r_pow_b, r_inv_b, r_tail_b;

    // Tables
    logic [AW-1:0] r_pre_mem_a [MAX_LEN];
    logic [BW-1:0] r_pre_mem_b [MAX_LEN];
    logic [AW-1:0] r_inv_mem_a [MAX_LEN];
    logic [BW-1:0] r_inv_mem_b [MAX_LEN];

    // Query operands
    logic [AW-1:0] r_hi_a, r_lo_a, r_invl_a, r_d_a, n_d_a;
    logic [BW-1:0] r_hi_b, r_lo_b, r_invl_b, r_d_b, n_d_b;

    // Result hold and output
    logic [AW-1:0] r_res_a, r_out_hash_a;
    logic [BW-1:0] r_res_b, r_out_hash_b;
    logic          r_res_err, r_out_err, r_out_valid;

    logic [AW-1:0] v_a, lo_a, term_opa_a, term_opb_a, term_y_a, pow_y_a, inv_y_a, n_tail_a;
    logic [BW-1:0] v_b, lo_b, term_opa_b, term_opb_b, term_y_b, pow_y_b, inv_y_b, n_tail_b;
    logic [AW:0]   sum_a;
    logic [BW:0]   sum_b;
    logic          term_vld, pow_vld, inv_vld;
    logic [IW-1:0] wr_idx, rd_hi, rd_lo, rd_inv;

    // Character value reduced into each field
    always_comb begin
        if (r_code >= dmsh_pkg::CHAR_OFFSET) begin
            v_a = AW'(r_code - dmsh_pkg::CHAR_OFFSET);
            v_b = BW'(r_code - dmsh_pkg::CHAR_OFFSET);
        end else begin
            v_a = dmsh_pkg::PRIME_A - AW'(dmsh_pkg::CHAR_OFFSET - r_code);
            v_b = dmsh_pkg::PRIME_B - BW'(dmsh_pkg::CHAR_OFFSET - r_code);
        end
    end

    // One unit serves the append term and the query product
    assign term_opa_a = i_cmd.issue_query ? r_d_a    : v_a;
    assign term_opb_a = i_cmd.issue_query ? r_invl_a : r_pow_a;
    assign term_opa_b = i_cmd.issue_query ? r_d_b    : v_b;
    assign term_opb_b = i_cmd.issue_query ? r_invl_b : r_pow_b;

    dmsh_modmul u_mul_term (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_cmd.issue_append | i_cmd.issue_query),
        .i_a_first  (term_opa_a),
        .i_b_first  (term_opb_a),
        .i_a_second (term_opa_b),
        .i_b_second (term_opb_b),
        .o_valid    (term_vld),
        .o_y_first  (term_y_a),
        .o_y_second (term_y_b)
    );

    dmsh_modmul u_mul_pow (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_cmd.issue_append),
        .i_a_first  (r_pow_a),
        .i_b_first  (AW'(dmsh_pkg::HASH_BASE)),
        .i_a_second (r_pow_b),
        .i_b_second (BW'(dmsh_pkg::HASH_BASE)),
        .o_valid    (pow_vld),
        .o_y_first  (pow_y_a),
        .o_y_second (pow_y_b)
    );

    dmsh_modmul u_mul_inv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_cmd.issue_append),
        .i_a_first  (r_inv_a),
        .i_b_first  (dmsh_pkg::BASE_INV_A),
        .i_a_second (r_inv_b),
        .i_b_second (dmsh_pkg::BASE_INV_B),
        .o_valid    (inv_vld),
        .o_y_first  (inv_y_a),
        .o_y_second (inv_y_b)
    );

    // New prefix: tail plus term, folded once
    always_comb begin
        sum_a = {1'b0, r_tail_a} + {1'b0, term_y_a};
        sum_b = {1'b0, r_tail_b} + {1'b0, term_y_b};
        n_tail_a = (sum_a >= (AW+1)'(dmsh_pkg::PRIME_A))
                 ? AW'(sum_a - (AW+1)'(dmsh_pkg::PRIME_A)) : AW'(sum_a);
        n_tail_b = (sum_b >= (BW+1)'(dmsh_pkg::PRIME_B))
                 ? BW'(sum_b - (BW+1)'(dmsh_pkg::PRIME_B)) : BW'(sum_b);
    end

    // Difference of prefixes; an empty left prefix reads as zero
    always_comb begin
        lo_a = (r_left == 10'd0) ? '0 : r_lo_a;
        lo_b = (r_left == 10'd0) ? '0 : r_lo_b;
        n_d_a = (r_hi_a >= lo_a) ? r_hi_a - lo_a : r_hi_a + (dmsh_pkg::PRIME_A - lo_a);
        n_d_b = (r_hi_b >= lo_b) ? r_hi_b - lo_b : r_hi_b + (dmsh_pkg::PRIME_B - lo_b);
    end

    assign wr_idx = r_len[IW-1:0];
    assign rd_hi  = IW'(r_right);
    assign rd_lo  = IW'(r_left - 10'd1);
    assign rd_inv = IW'(r_left);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_append) begin
            r_pre_mem_a[wr_idx] <= n_tail_a;
            r_pre_mem_b[wr_idx] <= n_tail_b;
            r_inv_mem_a[wr_idx] <= r_inv_a;
            r_inv_mem_b[wr_idx] <= r_inv_b;
        end
        if (i_cmd.read_query) begin
            r_hi_a   <= r_pre_mem_a[rd_hi];
            r_lo_a   <= r_pre_mem_a[rd_lo];
            r_hi_b   <= r_pre_mem_b[rd_hi];
            r_lo_b   <= r_pre_mem_b[rd_lo];
            r_invl_a <= r_inv_mem_a[rd_inv];
            r_invl_b <= r_inv_mem_b[rd_inv];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_code  <= i_req_code;
            r_left  <= i_req_left;
            r_right <= i_req_right;
        end
        if (i_cmd.diff_query) begin
            r_d_a <= n_d_a;
            r_d_b <= n_d_b;
        end
        if (i_cmd.hold_result) begin
            r_res_a   <= term_y_a;
            r_res_b   <= term_y_b;
            r_res_err <= 1'b0;
        end else if (i_cmd.hold_error) begin
            r_res_a   <= '0;
            r_res_b   <= '0;
            r_res_err <= 1'b1;
        end
        if (i_cmd.push) begin
            r_out_hash_a <= r_res_a;
            r_out_hash_b <= r_res_b;
            r_out_err    <= r_res_err;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pow_a     <= AW'(1);
            r_pow_b     <= BW'(1);
            r_inv_a     <= AW'(1);
            r_inv_b     <= BW'(1);
            r_tail_a    <= '0;
            r_tail_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_len    <= '0;
                r_pow_a  <= AW'(1);
                r_pow_b  <= BW'(1);
                r_inv_a  <= AW'(1);
                r_inv_b  <= BW'(1);
                r_tail_a <= '0;
                r_tail_b <= '0;
            end else if (i_cmd.commit_append) begin
                r_len    <= r_len + LW'(1);
                r_pow_a  <= pow_y_a;
                r_pow_b  <= pow_y_b;
                r_inv_a  <= inv_y_a;
                r_inv_b  <= inv_y_b;
                r_tail_a <= n_tail_a;
                r_tail_b <= n_tail_b;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.req_valid = i_req_valid;
        o_stat.kind      = dmsh_pkg::t_kind'(i_req_kind);
        o_stat.full      = (r_len == LW'(MAX_LEN));
        o_stat.range_bad = (i_req_left > i_req_right) || (CW'(i_req_right) >= CW'(r_len));
        o_stat.mul_done  = term_vld;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hash_first  = r_out_hash_a;
    assign o_hash_second = r_out_hash_b;
    assign o_range_error = r_out_err;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("stored length beyond capacity");

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_append |=> r_len == $past(r_len) + LW'(1))
        else $error("append commit did not advance length by one");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_hash_a == '0 && r_out_hash_b == '0))
        else $error("range error result carries non-zero hashes");

    a_pow_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pow_vld || inv_vld) |-> (pow_vld && inv_vld && term_vld))
        else $error("power multipliers out of step with the term multiplier");
`endif

endmodule

`default_nettype wire

@@ sv/dmsh_ctrl.sv @@
// Controller state machine sequencing clear, append and query requests.
`default_nettype none

module dmsh_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dmsh_pkg::t_stat i_stat,
    output dmsh_pkg::t_cmd       o_cmd,
    output logic                 o_ready
);

    typedef enum logic [7:0] {
        S_IDLE         = 8'b0000_0001,
        S_APPEND_ISSUE = 8'b0000_0010,
        S_APPEND_WAIT  = 8'b0000_0100,
        S_QUERY_READ   = 8'b0000_1000,
        S_QUERY_DIFF   = 8'b0001_0000,
        S_QUERY_ISSUE  = 8'b0010_0000,
        S_QUERY_WAIT   = 8'b0100_0000,
        S_PUSH         = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.req_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_stat.kind)
                        dmsh_pkg::KIND_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        dmsh_pkg::KIND_APPEND: begin
                            // drop the character when the string is full
                            if (!i_stat.full) n_state = S_APPEND_ISSUE;
                        end
                        dmsh_pkg::KIND_QUERY: begin
                            if (i_stat.range_bad) begin
                                o_cmd.hold_error = 1'b1;
                                n_state          = S_PUSH;
                            end else begin
                                n_state = S_QUERY_READ;
                            end
                        end
                        dmsh_pkg::KIND_NOP: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPEND_ISSUE: begin
                o_cmd.issue_append = 1'b1;
                n_state            = S_APPEND_WAIT;
            end
            S_APPEND_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.commit_append = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_QUERY_READ: begin
                o_cmd.read_query = 1'b1;
                n_state          = S_QUERY_DIFF;
            end
            S_QUERY_DIFF: begin
                o_cmd.diff_query = 1'b1;
                n_state          = S_QUERY_ISSUE;
            end
            S_QUERY_ISSUE: begin
                o_cmd.issue_query = 1'b1;
                n_state           = S_QUERY_WAIT;
            end
            S_QUERY_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.hold_result = 1'b1;
                    n_state           = S_PUSH;
                end
            end
            S_PUSH: begin
                // hold until the output slot drains
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

`ifndef ASSERT_OFF
    a_mul_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> (r_state == S_APPEND_WAIT || r_state == S_QUERY_WAIT))
        else $error("multiplier result outside a wait state");

    a_bad_query_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.kind == dmsh_pkg::KIND_QUERY && i_stat.range_bad)
        |=> r_state == S_PUSH)
        else $error("bad query did not go straight to the output");
`endif

endmodule

`default_nettype wire
